>>> src/ita_pkg.sv
// Shared constants, types and the digit-to-character function of the integer formatter.
package ita_pkg;

  // Sizing of the conversion
  localparam int VALUE_BITS = 64;
  localparam int MAX_DIGITS = 64;
  localparam int CHUNK_BITS = 8;
  localparam int CHUNKS     = (VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int QUOT_W     = CHUNKS * CHUNK_BITS;
  localparam int CHUNK_CW   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int DIG_AW     = $clog2(MAX_DIGITS);
  localparam int NUM_W      = $clog2(MAX_DIGITS + 1);

  // Field widths of the channels
  localparam int VALUE_W = 64;
  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 7;
  localparam int DIGIT_W = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] UPPER_OFS = 8'h07;
  localparam logic [CHAR_W-1:0] LOWER_OFS = 8'h27;

  typedef struct packed {
    logic start;
    logic load;
  } div_ctrl_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] digit;
    logic               quot_zero;
  } div_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] c;
    c = CHAR_W'(d) + CHAR_ZERO;
    if (c > CHAR_NINE) begin
      c = c + (upper ? UPPER_OFS : LOWER_OFS);
    end
    return c;
  endfunction

endpackage

>>> src/ita_if.sv
// Valid/ready channel interfaces for the formatter's input items and output characters.
interface ita_in_if;
  import ita_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [RADIX_W-1:0] radix;
  logic               upper_case;
  logic [CHAR_W-1:0]  fill_char;
  logic [COUNT_W-1:0] min_width;
  logic               pad_before;

  modport source (output valid, value, radix, upper_case, fill_char, min_width, pad_before,
                  input ready);
  modport sink   (input valid, value, radix, upper_case, fill_char, min_width, pad_before,
                  output ready);
endinterface

interface ita_out_if;
  import ita_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  char_out;
  logic               last;
  logic [COUNT_W-1:0] total_count;

  modport source (output valid, char_out, last, total_count, input ready);
  modport sink   (input valid, char_out, last, total_count, output ready);
endinterface

>>> src/integer_to_ascii_formatter.sv
// Top level of the integer formatter: sequencer, digit memory and output register.
// Usage:
//   item  - input channel, one word per conversion: value, radix (values below two
//           act as two, above sixteen as sixteen), upper_case, fill_char,
//           min_width (saturated to 64) and pad_before.
//   text  - output channel, one word per character, most significant digit
//           first, with fill before or after the digits. The final word has
//           last set and total_count = max(digits, width); earlier words carry 0.
// Sequence:
//   The shared divider works through the 64-bit quotient one 8-bit chunk a
//   cycle, then the digit is stored; conversion repeats this for each digit.
//   Emission then takes a digit memory read and an output register load
//   for each character while the receiver keeps ready high.
//   item.ready is high only while no conversion is in progress; the final
//   character may still wait in the output register while the next word is
//   accepted.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// Stall: a stalled receiver holds the current word in the output register and
//   freezes the emission sequence; nothing is dropped or repeated.
module integer_to_ascii_formatter (
  input logic clk,
  input logic rst,
  ita_in_if.sink   item,
  ita_out_if.source text
);
  import ita_pkg::*;

  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] S_IDLE  = 2'd0;
  localparam logic [STATE_W-1:0] S_DIV   = 2'd1;
  localparam logic [STATE_W-1:0] S_FETCH = 2'd2;
  localparam logic [STATE_W-1:0] S_PUT   = 2'd3;

  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(MAX_DIGITS);

  logic [STATE_W-1:0] state;
  logic [NUM_W-1:0]   n;          // digits stored so far
  logic [NUM_W-1:0]   n_inc;
  logic [NUM_W-1:0]   width_sat;
  logic [NUM_W-1:0]   total;
  logic [NUM_W-1:0]   pos;        // character being emitted
  logic               upper;
  logic [CHAR_W-1:0]  fill;
  logic               pad_first;

  logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_digit;
  logic [DIG_AW-1:0]  rd_idx;

  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_last;
  logic [COUNT_W-1:0] out_count;

  logic               accept;
  logic               finish;
  logic               is_fill;
  logic               is_last;
  logic               put_ok;
  logic [RADIX_W-1:0] radix_clamped;

  div_ctrl_t          div_ctrl;
  div_status_t        div_status;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;

  // Clamp the radix into the supported range
  always_comb begin
    if (item.radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (item.radix > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = item.radix;
    end
  end

  // Stop once the quotient runs out or the digit memory is full
  assign n_inc  = n + 1'b1;
  assign finish = div_status.quot_zero || (n_inc == NUM_W'(MAX_DIGITS));

  // Restart the divider on the quotient until the conversion finishes
  assign div_ctrl.start = accept || ((state == S_DIV) && div_status.done && !finish);
  assign div_ctrl.load  = accept;

  ita_div u_div (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (div_ctrl),
    .value  (item.value),
    .radix  (radix_clamped),
    .status (div_status)
  );

  // Map the output position onto fill or a stored digit
  always_comb begin
    if (pad_first) begin
      is_fill = (pos < (total - n));
      rd_idx  = DIG_AW'(total - 1'b1 - pos);
    end else begin
      is_fill = (pos >= n);
      rd_idx  = DIG_AW'(n - 1'b1 - pos);
    end
  end

  assign is_last = (pos == (total - 1'b1));
  assign put_ok  = !out_valid || text.ready;

  always_ff @(posedge clk) begin
    if ((state == S_DIV) && div_status.done) begin
      digit_mem[n[DIG_AW-1:0]] <= div_status.digit;
    end
    if (state == S_FETCH) begin
      rd_digit <= digit_mem[rd_idx];
    end
  end

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new word, else drop the one the receiver took
      if ((state == S_PUT) && put_ok) begin
        out_valid <= 1'b1;
      end else if (text.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n     <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_status.done) begin
            n <= n_inc;
            if (finish) begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_PUT;
        end
        S_PUT: begin
          if (put_ok) begin
            state <= is_last ? S_IDLE : S_FETCH;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latched job fields, counters and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      upper     <= item.upper_case;
      fill      <= item.fill_char;
      pad_first <= item.pad_before;
      width_sat <= (item.min_width > CAP) ? NUM_W'(MAX_DIGITS) : NUM_W'(item.min_width);
    end
    if ((state == S_DIV) && div_status.done && finish) begin
      total <= (width_sat > n_inc) ? width_sat : n_inc;
      pos   <= '0;
    end
    if ((state == S_PUT) && put_ok) begin
      out_char  <= is_fill ? fill : digit_char(rd_digit, upper);
      out_last  <= is_last;
      out_count <= is_last ? COUNT_W'(total) : '0;
      pos       <= pos + 1'b1;
    end
  end

  assign text.valid       = out_valid;
  assign text.char_out    = out_char;
  assign text.last        = out_last;
  assign text.total_count = out_count;

endmodule

>>> src/ita_div.sv
// Iterative divider by a small radix: one quotient chunk per cycle, remainder out as a digit.
module ita_div (
  input  logic                          clk,
  input  logic                          rst,
  input  ita_pkg::div_ctrl_t            ctrl,
  input  logic [ita_pkg::VALUE_W-1:0]   value,
  input  logic [ita_pkg::RADIX_W-1:0]   radix,
  output ita_pkg::div_status_t          status
);
  import ita_pkg::*;

  logic [QUOT_W-1:0]     quot;
  logic [QUOT_W-1:0]     quot_next;
  logic [DIGIT_W-1:0]    rem;
  logic [DIGIT_W-1:0]    rem_next;
  logic [RADIX_W-1:0]    base;
  logic [CHUNK_CW-1:0]   chunk;
  logic                  busy;
  logic                  done;
  logic [DIGIT_W-1:0]    digit;
  logic                  quot_zero;
  logic [CHUNK_BITS-1:0] qbits;
  logic                  last_chunk;

  // Long division of the next chunk, most significant bit first
  always_comb begin
    logic [DIGIT_W:0]   acc;
    logic [DIGIT_W-1:0] r;
    r = rem;
    qbits = '0;
    for (int j = 0; j < CHUNK_BITS; j++) begin
      acc = {r, quot[QUOT_W-1-j]};
      if (acc >= base) begin
        acc = acc - base;
        qbits[CHUNK_BITS-1-j] = 1'b1;
      end
      r = acc[DIGIT_W-1:0];
    end
    rem_next  = r;
    quot_next = (quot << CHUNK_BITS) | QUOT_W'(qbits);
  end

  assign last_chunk = (chunk == CHUNK_CW'(CHUNKS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && last_chunk) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      chunk <= '0;
      rem   <= '0;
      if (ctrl.load) begin
        quot <= QUOT_W'(value[VALUE_BITS-1:0]);
        base <= radix;
      end
    end else if (busy) begin
      quot  <= quot_next;
      rem   <= rem_next;
      chunk <= chunk + 1'b1;
      if (last_chunk) begin
        digit     <= rem_next;
        quot_zero <= (quot_next == '0);
      end
    end
  end

  assign status.done      = done;
  assign status.digit     = digit;
  assign status.quot_zero = quot_zero;

endmodule

>>> src/ita_checker.sv
// Port-level assertions for the integer formatter, bound to its top level.
module ita_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ita_pkg::CHAR_W-1:0]   char_out,
  input logic                         last,
  input logic [ita_pkg::COUNT_W-1:0]  total_count
);
  import ita_pkg::*;

  // Hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last)
      && $stable(total_count))
    else $error("output word changed while stalled");

  // Drop the input side once a word is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

  // Keep the input closed while a run is still being emitted
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input ready in the middle of a character run");

  a_count_zero_early: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> total_count == '0)
    else $error("count nonzero before the last character");

  a_count_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> (total_count != '0) && (total_count <= COUNT_W'(MAX_DIGITS)))
    else $error("count out of range on the last character");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (text.valid),
  .out_ready   (text.ready),
  .char_out    (text.char_out),
  .last        (text.last),
  .total_count (text.total_count)
);

>>> tb/integer_to_ascii_formatter_tb.sv
// Self-checking testbench for the integer-to-ASCII formatter: directed and random conversions.
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;
  import ita_pkg::*;

  // ASCII anchors used to build expected characters
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam int                WIDTH_CAP     = 64;
  localparam int                RANDOM_ITEMS  = 188;
  localparam int                DRAIN_CYCLES  = 40;

  // One expected output word
  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] count;
  } text_word_t;

  // Scoreboard: turns each accepted item into its expected text, then
  // matches the characters coming out of the block in order.
  class text_scoreboard;
    text_word_t  text_q[$];
    int          fail_count;
    int unsigned char_index;

    function new();
      fail_count = 0;
      char_index = 0;
    endfunction

    function int pending();
      return text_q.size();
    endfunction

    function logic [CHAR_W-1:0] ascii_digit(logic [DIGIT_W-1:0] d, logic upper);
      if (d < 4'd10) begin
        return ASCII_ZERO + CHAR_W'(d);
      end
      return (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + CHAR_W'(d) - 8'd10;
    endfunction

    function void note_item(logic [VALUE_W-1:0] value, logic [RADIX_W-1:0] radix_in,
                            logic upper, logic [CHAR_W-1:0] fill,
                            logic [COUNT_W-1:0] width_in, logic pad_first);
      logic [VALUE_W-1:0] rest;
      logic [VALUE_W-1:0] base;
      logic [DIGIT_W-1:0] digits [WIDTH_CAP];
      int                 width;
      int                 n;
      int                 pad;
      int                 total;
      text_word_t         w;
      rest = value;
      // Clamp radix into 2..16 and width to the digit capacity
      if (radix_in < RADIX_MIN) begin
        base = VALUE_W'(RADIX_MIN);
      end else if (radix_in > RADIX_MAX) begin
        base = VALUE_W'(RADIX_MAX);
      end else begin
        base = VALUE_W'(radix_in);
      end
      width = (int'(width_in) > WIDTH_CAP) ? WIDTH_CAP : int'(width_in);
      n = 0;
      if (rest == '0) begin
        digits[0] = '0;
        n = 1;
      end else begin
        while (rest != '0 && n < WIDTH_CAP) begin
          digits[n] = DIGIT_W'(rest % base);
          rest = rest / base;
          n++;
        end
      end
      pad   = (width > n) ? width - n : 0;
      total = n + pad;
      // Emit fill and digits, most significant digit first
      for (int k = 0; k < total; k++) begin
        if (pad_first) begin
          w.ch = (k < pad) ? fill : ascii_digit(digits[n - 1 - (k - pad)], upper);
        end else begin
          w.ch = (k < n) ? ascii_digit(digits[n - 1 - k], upper) : fill;
        end
        w.last  = (k == total - 1);
        w.count = w.last ? COUNT_W'(total) : '0;
        text_q.push_back(w);
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
    endtask

    task check_char(logic [CHAR_W-1:0] ch, logic last, logic [COUNT_W-1:0] count);
      text_word_t w;
      if (text_q.size() == 0) begin
        report_mismatch($sformatf("char %0d: unexpected word %h", char_index, ch));
      end else begin
        w = text_q.pop_front();
        if (ch !== w.ch) begin
          report_mismatch($sformatf("char %0d: char_out %h, want %h", char_index, ch, w.ch));
        end
        if (last !== w.last) begin
          report_mismatch($sformatf("char %0d: last %b, want %b", char_index, last, w.last));
        end
        if (count !== w.count) begin
          report_mismatch($sformatf("char %0d: total_count %0d, want %0d",
                                    char_index, count, w.count));
        end
      end
      char_index++;
    endtask
  endclass

  logic clk;
  logic rst;

  ita_in_if  item_ch ();
  ita_out_if text_ch ();

  integer_to_ascii_formatter u_dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .text (text_ch)
  );

  text_scoreboard sb;

  // Idle controls: set both to run a stretch with no gaps on either side
  bit tx_quiet;
  bit rx_steady;

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // Gap length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 40);
  endfunction

  // Drop valid and scramble the payload for the given gap; call at a falling edge
  task automatic hold_off(int n);
    if (n > 0) begin
      item_ch.valid      <= 1'b0;
      item_ch.value      <= {$urandom, $urandom};
      item_ch.radix      <= RADIX_W'($urandom);
      item_ch.upper_case <= 1'($urandom);
      item_ch.fill_char  <= CHAR_W'($urandom);
      item_ch.min_width  <= COUNT_W'($urandom);
      item_ch.pad_before <= 1'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  // Present one word, hold it until accepted, log it with the scoreboard
  task automatic send_item(logic [VALUE_W-1:0] value, logic [RADIX_W-1:0] radix,
                           logic upper, logic [CHAR_W-1:0] fill,
                           logic [COUNT_W-1:0] width, logic pad_first);
    hold_off(tx_quiet ? 0 : pick_gap());
    item_ch.valid      <= 1'b1;
    item_ch.value      <= value;
    item_ch.radix      <= radix;
    item_ch.upper_case <= upper;
    item_ch.fill_char  <= fill;
    item_ch.min_width  <= width;
    item_ch.pad_before <= pad_first;
    do begin
      @(posedge clk);
    end while (!item_ch.ready);
    sb.note_item(value, radix, upper, fill, width, pad_first);
    @(negedge clk);
  endtask

  // Build a random word with a spread of digit counts, radixes and widths
  task automatic send_random();
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
    logic [COUNT_W-1:0] width;
    case ($urandom_range(0, 3))
      0: value = {$urandom, $urandom};
      1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: value = VALUE_W'($urandom_range(0, 1000));
      default: begin
        case ($urandom_range(0, 2))
          0: value = '0;
          1: value = '1;
          default: value = VALUE_W'(1) << $urandom_range(0, 63);
        endcase
      end
    endcase
    radix = ($urandom_range(0, 9) == 0) ? RADIX_W'($urandom) :
            RADIX_W'($urandom_range(2, 16));
    case ($urandom_range(0, 19))
      0, 1, 2:    width = COUNT_W'($urandom_range(65, 127));
      3, 4, 5, 6: width = COUNT_W'($urandom_range(0, 64));
      default:    width = COUNT_W'($urandom_range(0, 24));
    endcase
    send_item(value, radix, 1'($urandom), CHAR_W'($urandom), width, 1'($urandom));
  endtask

  // Lower valid and wait until every expected character has come out
  task automatic drain_text();
    item_ch.valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
  endtask

  // Receiver: toggle ready in runs, hold it high in steady stretches
  initial begin
    int left;
    bit level;
    text_ch.ready = 1'b0;
    left  = 0;
    level = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_steady) begin
        level = 1'b1;
        left  = 0;
      end else if (left <= 0) begin
        if (!level) begin
          level = 1'b1;
          left  = $urandom_range(1, 16);
        end else begin
          left  = pick_gap();
          level = (left == 0);
          if (left == 0) begin
            left = 1;
          end
        end
      end
      text_ch.ready <= level;
      left--;
    end
  end

  // Check every accepted output word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready) begin
      sb.check_char(text_ch.char_out, text_ch.last, text_ch.total_count);
    end
  end

  // Main sequence
  initial begin
    sb        = new();
    tx_quiet  = 1'b0;
    rx_steady = 1'b0;
    rst       = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.value      = '0;
    item_ch.radix      = '0;
    item_ch.upper_case = 1'b0;
    item_ch.fill_char  = '0;
    item_ch.min_width  = '0;
    item_ch.pad_before = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Zero value: single '0' digit, with and without padding
    send_item('0, 5'd10, 1'b0, 8'h20, 7'd0, 1'b0);
    send_item('0, 5'd10, 1'b0, 8'h2A, 7'd64, 1'b1);
    send_item('0, 5'd16, 1'b1, 8'h00, 7'd3, 1'b0);
    // All ones: longest digit strings in binary, octal, decimal and hex, both cases
    send_item('1, 5'd2, 1'b0, 8'h20, 7'd0, 1'b1);
    send_item('1, 5'd8, 1'b0, 8'h20, 7'd0, 1'b1);
    send_item('1, 5'd16, 1'b1, 8'h20, 7'd0, 1'b1);
    send_item('1, 5'd16, 1'b0, 8'hFF, 7'd64, 1'b0);
    send_item('1, 5'd10, 1'b1, 8'h5F, 7'd64, 1'b1);
    // Top bit set stays unsigned
    send_item(64'h8000_0000_0000_0000, 5'd10, 1'b0, 8'h20, 7'd0, 1'b0);
    send_item(64'hFEDC_BA98_7654_3210, 5'd16, 1'b0, 8'h20, 7'd20, 1'b1);
    // Radix below two acts as two, above sixteen as sixteen
    send_item(64'd1234, 5'd0, 1'b0, 8'h20, 7'd0, 1'b0);
    send_item(64'd1234, 5'd1, 1'b0, 8'h20, 7'd0, 1'b0);
    send_item(64'h00AB_CDEF, 5'd17, 1'b1, 8'h20, 7'd0, 1'b0);
    send_item(64'h00AB_CDEF, 5'd31, 1'b0, 8'h20, 7'd0, 1'b0);
    // Width above capacity saturates to 64
    send_item(64'd255, 5'd16, 1'b1, 8'h30, 7'd127, 1'b1);
    send_item(64'd255, 5'd16, 1'b0, 8'h2E, 7'd65, 1'b0);
    // Padding on both sides, odd radixes, width equal to digit count
    send_item(64'd255, 5'd16, 1'b1, 8'h30, 7'd5, 1'b1);
    send_item(64'd255, 5'd16, 1'b1, 8'h20, 7'd5, 1'b0);
    send_item(64'd1, 5'd2, 1'b0, 8'h20, 7'd1, 1'b1);
    send_item(64'd1_000_000, 5'd3, 1'b0, 8'h2D, 7'd13, 1'b1);
    send_item(64'd987_654_321, 5'd7, 1'b0, 8'h2D, 7'd12, 1'b0);
    send_item(64'hDEAD_BEEF_CAFE_F00D, 5'd13, 1'b1, 8'h7E, 7'd40, 1'b1);

    // Random part with gaps on both sides
    repeat (RANDOM_ITEMS * 2 / 5) send_random();

    // Hold the sender until the block has emitted everything
    drain_text();

    // Back-to-back stretch: no gaps on either side
    tx_quiet  = 1'b1;
    rx_steady = 1'b1;
    repeat (RANDOM_ITEMS / 5) send_random();
    tx_quiet  = 1'b0;
    rx_steady = 1'b0;

    repeat (RANDOM_ITEMS - RANDOM_ITEMS * 2 / 5 - RANDOM_ITEMS / 5) send_random();

    // Drop valid, wait out every expected character, then a short tail
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
